@@ rtl/slwd_pkg.sv @@
// ----------------------------------------------------------------------------
// slwd_pkg: sound level window detector shared definitions
// Field types, window geometry and the reciprocal used for the average.
// ----------------------------------------------------------------------------
package slwd_pkg;

    localparam int WINDOW_LEN = 100;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int LEVEL_W  = 15;
    localparam int DETECT_W = 12;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam int SUM_W = MAG_W + $clog2(WINDOW_LEN);

    // floor(sum / WINDOW_LEN) as (sum * DIV_RECIP) >> DIV_SHIFT; exact for any sum
    // below 2**SUM_W because the rounding error stays under 1 / WINDOW_LEN.
    localparam int DIV_SHIFT = SUM_W + 2 * $clog2(WINDOW_LEN);
    localparam int RECIP_W   = DIV_SHIFT - $clog2(WINDOW_LEN) + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint unsigned DIV_RECIP_L =
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(DIV_RECIP_L);

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam logic [DETECT_W-1:0] DETECT_RESET = 12'd64;
    localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 16'd508;

    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_LEVEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_OFFSET    = 1'd1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               above;
    } t_out;

    // per-cycle control broadcast along the window chain
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

@@ rtl/slwd_cell.sv @@
// ----------------------------------------------------------------------------
// slwd_cell: one window cell
// Holds one magnitude, passes it to the next cell on every shift; clear zeroes it.
// ----------------------------------------------------------------------------
module slwd_cell import slwd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  logic [MAG_W-1:0] i_mag,
    output logic [MAG_W-1:0] o_mag
);

    logic [MAG_W-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_mag <= '0;
        end else if (i_ctrl.shift) begin
            r_mag <= i_mag;
        end
    end

    assign o_mag = r_mag;

endmodule

@@ rtl/slwd_avg.sv @@
// ----------------------------------------------------------------------------
// slwd_avg: window average and level compare
// Three-stage elastic pipeline: sum capture, reciprocal multiply, compare.
// ----------------------------------------------------------------------------
module slwd_avg import slwd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [SUM_W-1:0]    i_sum,
    input  logic [DETECT_W-1:0] i_detect_level,
    input  logic                i_stall,
    output logic                o_full,
    output logic                o_valid,
    output t_out                o_res
);

    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic [PROD_W-1:0] r_prod;
    t_out              r_res;

    logic              en1;
    logic              en2;
    logic              en3;
    logic [LEVEL_W-1:0] w_level;

    assign en3 = !r_v3 || !i_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign w_level = r_prod[DIV_SHIFT +: LEVEL_W];

    // stage 1 payload is the live running sum: it cannot move while stage 1 holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_load;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(DIV_RECIP);
        end
        if (en3 && r_v2) begin
            r_res.level <= w_level;
            r_res.above <= w_level > LEVEL_W'(i_detect_level);
        end
    end

    assign o_full  = !en1;
    assign o_valid = r_v3;
    assign o_res   = r_res;

endmodule

@@ rtl/sound_level_window_detector.sv @@
// ----------------------------------------------------------------------------
// sound_level_window_detector: moving average sound level detector
// Offset, rectify, sliding window sum and thresholded average per sample.
// ----------------------------------------------------------------------------
// One sample transfer per clock while o_stall is low; each transfer (sample or
// clear) yields one result via sum capture, multiply and compare stages. The
// window is a chain of WINDOW_LEN register cells that shifts once per sample,
// so the oldest magnitude is always at the chain end and the running sum is
// updated incrementally. The average uses a constant reciprocal multiply then
// the threshold compare, one stage each. Stalls back up without losing a result.
module sound_level_window_detector import slwd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_in_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [DETECT_W-1:0]        r_detect_level;
    logic signed [SAMPLE_W-1:0] r_dc_offset;
    logic [SUM_W-1:0]           r_sum;
    logic [SUM_W-1:0]           n_sum;

    logic                       accept;
    logic                       avg_full;
    logic signed [SAMPLE_W:0]   w_ofs;
    logic [MAG_W-1:0]           n_mag;
    t_cell_ctrl                 cell_ctrl;
    logic [MAG_W-1:0]           w_tap [WINDOW_LEN];

    assign o_stall = avg_full;
    assign accept  = i_valid && !avg_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_level <= DETECT_RESET;
            r_dc_offset    <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DETECT_LEVEL: r_detect_level <= i_cfg_data[DETECT_W-1:0];
                CFG_DC_OFFSET:    r_dc_offset    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // offset add, then saturating magnitude
    assign w_ofs = {i_in_data.sample[SAMPLE_W-1], i_in_data.sample}
                 + {r_dc_offset[SAMPLE_W-1], r_dc_offset};

    always_comb begin
        if (w_ofs >= 17'sd32767 || w_ofs <= -17'sd32767) begin
            n_mag = MAG_MAX;
        end else if (w_ofs < 17'sd0) begin
            n_mag = MAG_W'(-w_ofs);
        end else begin
            n_mag = MAG_W'(w_ofs);
        end
    end

    assign cell_ctrl.shift = accept && (i_in_data.cmd == CMD_SAMPLE);
    assign cell_ctrl.clear = accept && (i_in_data.cmd == CMD_CLEAR);

    genvar k;
    generate
        for (k = 0; k < WINDOW_LEN; k++) begin : g_cell
            if (k == 0) begin : g_head
                slwd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (cell_ctrl),
                    .i_mag   (n_mag),
                    .o_mag   (w_tap[k])
                );
            end else begin : g_body
                slwd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (cell_ctrl),
                    .i_mag   (w_tap[k-1]),
                    .o_mag   (w_tap[k])
                );
            end
        end
    endgenerate

    // oldest entry leaves at the chain end as the new one enters
    assign n_sum = r_sum - SUM_W'(w_tap[WINDOW_LEN-1]) + SUM_W'(n_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cell_ctrl.clear) begin
            r_sum <= '0;
        end else if (cell_ctrl.shift) begin
            r_sum <= n_sum;
        end
    end

    slwd_avg u_avg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_sum          (r_sum),
        .i_detect_level (r_detect_level),
        .i_stall        (i_stall),
        .o_full         (avg_full),
        .o_valid        (o_valid),
        .o_res          (o_out_data)
    );

endmodule
